>>> design/dcs_pkg.sv
package dcs_pkg;

  // event kinds carried on in_tuser
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_EVAL  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  // phase codes
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PREHEAT = 2'd1;
  localparam logic [1:0] PH_DRY     = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_TARGET      = 3'd0;
  localparam logic [2:0] REG_HYST        = 3'd1;
  localparam logic [2:0] REG_TOTAL       = 3'd2;
  localparam logic [2:0] REG_PREHEAT     = 3'd3;
  localparam logic [2:0] REG_AGIT_PERIOD = 3'd4;
  localparam logic [2:0] REG_AGIT_SECS   = 3'd5;
  localparam logic [2:0] REG_EXH_PERIOD  = 3'd6;
  localparam logic [2:0] REG_EXH_SECS    = 3'd7;

  localparam int SEC_W  = 17;
  localparam int WIN_W  = 12;
  localparam int MIN_W  = 11;
  localparam int TEMP_W = 12;

  // result beat layout on out_tdata
  localparam int OUT_HEATER = 0;
  localparam int OUT_FAN    = 1;
  localparam int OUT_SERVO  = 2;
  localparam int OUT_PH_LO  = 3;
  localparam int OUT_PH_HI  = 4;
  localparam int OUT_REM_LO = 5;
  localparam int OUT_REM_HI = 21;
  localparam int OUT_FIN    = 22;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic             heater;
    logic             fan;
    logic             servo;
    logic [1:0]       phase;
    logic [SEC_W-1:0] total_left;
    logic [SEC_W-1:0] preheat_left;
    logic [SEC_W-1:0] until_agit;
    logic [WIN_W-1:0] agit_left;
    logic [SEC_W-1:0] until_exh;
    logic [WIN_W-1:0] exh_left;
  } seq_state_t;

  // minutes to seconds: m * 60 = m * 64 - m * 4
  function automatic logic [SEC_W-1:0] min_to_sec(input logic [MIN_W-1:0] m);
    logic [SEC_W-1:0] mx;
    mx = {{(SEC_W-MIN_W){1'b0}}, m};
    return (mx << 6) - (mx << 2);
  endfunction

endpackage

>>> design/dryer_cycle_sequencer.sv
// an accepted event beat passes the event register, then the result register,
// before its result beat is offered; throughput: one event per cycle unless
// out_tready stalls the result beat; the state update is a single pass of logic
// reset: synchronous active-low rst_n returns to idle with all drives off,
// counters cleared and configuration registers at their defaults
module dryer_cycle_sequencer
  import dcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [11:0] temperature_tenths (signed)
  input  logic [1:0]            in_tuser,   // [1:0] mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] heater_drive, [1] fan_drive, [2] servo_drive, [4:3] phase,
  // [21:5] remaining_seconds, [22] cycle_finished, [23] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [11:0]           cfg_data
);

  logic [10:0] target_r;
  logic [8:0]  hyst_r;
  logic [10:0] total_min_r;
  logic [10:0] preheat_min_r;
  logic [10:0] agit_period_r;
  logic [11:0] agit_secs_r;
  logic [10:0] exh_period_r;
  logic [11:0] exh_secs_r;

  logic              s1_valid_r;
  logic [1:0]        s1_mode_r;
  logic [TEMP_W-1:0] s1_temp_r;

  seq_state_t st_r, st_nxt;
  logic       fin_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic advance;
  logic s1_fire;

  assign cfg_ready  = 1'b1;
  assign advance    = !out_valid_r || out_tready;
  assign s1_fire    = s1_valid_r && advance;
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  function automatic logic [SEC_W-1:0] dec_sec(input logic [SEC_W-1:0] v);
    return (v != '0) ? v - 1'b1 : v;
  endfunction

  function automatic logic [WIN_W-1:0] dec_win(input logic [WIN_W-1:0] v);
    return (v != '0) ? v - 1'b1 : v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r      <= 11'd800;
      hyst_r        <= 9'd50;
      total_min_r   <= 11'd360;
      preheat_min_r <= 11'd30;
      agit_period_r <= 11'd20;
      agit_secs_r   <= 12'd60;
      exh_period_r  <= 11'd30;
      exh_secs_r    <= 12'd120;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET:      target_r      <= cfg_data[10:0];
        REG_HYST:        hyst_r        <= cfg_data[8:0];
        REG_TOTAL:       total_min_r   <= cfg_data[10:0];
        REG_PREHEAT:     preheat_min_r <= cfg_data[10:0];
        REG_AGIT_PERIOD: agit_period_r <= cfg_data[10:0];
        REG_AGIT_SECS:   agit_secs_r   <= cfg_data[11:0];
        REG_EXH_PERIOD:  exh_period_r  <= cfg_data[10:0];
        REG_EXH_SECS:    exh_secs_r    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // event register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mode_r <= in_tuser;
      s1_temp_r <= in_tdata[TEMP_W-1:0];
    end
  end

  // single-pass state update
  always_comb begin
    logic signed [12:0] temp_s;
    logic signed [12:0] target_s;
    logic signed [12:0] low_s;
    logic               exh_start;
    logic               agit_start;

    st_nxt   = st_r;
    fin_nxt  = 1'b0;
    temp_s   = {s1_temp_r[TEMP_W-1], s1_temp_r};
    target_s = $signed({2'b00, target_r});
    low_s    = target_s - $signed({4'b0000, hyst_r});
    exh_start  = 1'b0;
    agit_start = 1'b0;

    case (s1_mode_r)
      MODE_TICK: begin
        if (st_r.phase != PH_IDLE) begin
          st_nxt.total_left   = dec_sec(st_r.total_left);
          st_nxt.preheat_left = dec_sec(st_r.preheat_left);
          st_nxt.until_agit   = dec_sec(st_r.until_agit);
          st_nxt.agit_left    = dec_win(st_r.agit_left);
          st_nxt.until_exh    = dec_sec(st_r.until_exh);
          st_nxt.exh_left     = dec_win(st_r.exh_left);
        end
      end
      MODE_EVAL: begin
        if (st_r.phase != PH_IDLE) begin
          if (temp_s < low_s) begin
            st_nxt.heater = 1'b1;
          end else if (temp_s >= target_s) begin
            st_nxt.heater = 1'b0;
          end
          if (st_r.phase == PH_PREHEAT) begin
            if (st_r.preheat_left == '0) begin
              st_nxt.phase = PH_DRY;
            end
          end else if (st_r.total_left == '0) begin
            st_nxt.heater = 1'b0;
            st_nxt.fan    = 1'b0;
            st_nxt.servo  = 1'b0;
            st_nxt.phase  = PH_IDLE;
            fin_nxt       = 1'b1;
          end else begin
            // exhaust has priority; agitation sees the exhaust counter after it
            exh_start = (st_r.exh_left == '0) && (st_r.until_exh == '0) &&
                        (st_r.agit_left == '0);
            if (exh_start) begin
              st_nxt.servo     = 1'b1;
              st_nxt.fan       = 1'b1;
              st_nxt.exh_left  = exh_secs_r;
              st_nxt.until_exh = min_to_sec(exh_period_r);
            end
            agit_start = (st_r.agit_left == '0) && (st_r.until_agit == '0) &&
                         (st_nxt.exh_left == '0);
            if (agit_start) begin
              st_nxt.fan        = 1'b1;
              st_nxt.agit_left  = agit_secs_r;
              st_nxt.until_agit = min_to_sec(agit_period_r);
            end
            if (st_nxt.fan && (st_nxt.agit_left == '0) && (st_nxt.exh_left == '0)) begin
              st_nxt.fan   = 1'b0;
              st_nxt.servo = 1'b0;
            end
          end
        end
      end
      MODE_START: begin
        if (st_r.phase == PH_IDLE) begin
          st_nxt.total_left   = min_to_sec(total_min_r);
          st_nxt.preheat_left = min_to_sec(preheat_min_r);
          st_nxt.until_exh    = min_to_sec(exh_period_r);
          st_nxt.until_agit   = min_to_sec(agit_period_r);
          st_nxt.phase        = PH_PREHEAT;
        end
      end
      MODE_STOP: begin
        st_nxt.heater = 1'b0;
        st_nxt.fan    = 1'b0;
        st_nxt.servo  = 1'b0;
        st_nxt.phase  = PH_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= {1'b0, fin_nxt, st_nxt.total_left, st_nxt.phase,
                     st_nxt.servo, st_nxt.fan, st_nxt.heater};
    end
  end

endmodule

>>> design/dcs_checker.sv
module dcs_checker
  import dcs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [1:0] phase;
  logic       drives_off;

  assign phase      = out_tdata[OUT_PH_HI:OUT_PH_LO];
  assign drives_off = !out_tdata[OUT_HEATER] && !out_tdata[OUT_FAN] &&
                      !out_tdata[OUT_SERVO];

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // idle always means every drive is off
  a_idle_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (phase == PH_IDLE) |-> drives_off)
    else $error("drive on while idle");

  // the servo only opens together with the fan
  a_servo_fan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_SERVO] |-> out_tdata[OUT_FAN])
    else $error("servo open with fan off");

  // timeout lands in idle with nothing left on the clock
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_FIN] |->
      (phase == PH_IDLE) && (out_tdata[OUT_REM_HI:OUT_REM_LO] == '0))
    else $error("finished flag outside a timeout");

endmodule

bind dryer_cycle_sequencer dcs_checker u_dcs_checker (.*);
